### hw/rtl/lrup_pkg.sv
`timescale 1ns / 1ps

package lrup_pkg;

  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 5;
  localparam int COUNT_W = 32;

  localparam logic [FRAME_W-1:0] FRAMES_RESET = FRAME_W'(4);

  // carried from each cell to the one below it
  typedef struct packed {
    logic              seen;    // a match sits at this depth or above
    logic [PAGE_W-1:0] victim;  // entry of the bottom cell, zero above it
  } chain_t;

endpackage

### hw/rtl/lrup_cell.sv
`timescale 1ns / 1ps

module lrup_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [lrup_pkg::PAGE_W-1:0]  page,
  input  logic [lrup_pkg::PAGE_W-1:0]  prev_entry,
  input  logic                         valid,
  input  logic                         bottom,
  input  lrup_pkg::chain_t             chain_in,
  output lrup_pkg::chain_t             chain_out,
  output logic [lrup_pkg::PAGE_W-1:0]  entry
);

  logic match;

  assign match = valid && (entry == page);

  always_comb begin
    chain_out.seen   = chain_in.seen | match;
    chain_out.victim = chain_in.victim | (bottom ? entry : '0);
  end

  // the hit cell and the cells above it (or all cells on a miss) take their upper neighbor
  always_ff @(posedge clk) begin
    if (shift_en && !chain_in.seen) begin
      entry <= prev_entry;
    end
  end

endmodule

### hw/rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps

// LRU replacement stack, one page reference per word.
// Input channel: page with in_valid/in_ready. Output channel: fault,
// evicted_valid, evicted_page and fault_total with out_valid/out_ready.
// The stack is a row of MAX_FRAMES cells; every cell compares its entry with
// the page in parallel, and a hit flag ripples down the row so that the hit
// cell and the cells above it (or every cell on a miss) shift down by one while
// the page enters at the top. One word is taken per cycle while in_ready is
// high; the result is registered for the cycle after acceptance. The clock
// period is set by the hit ripple through the row of cells and the bottom-entry pick.
// A single output register holds the result; in_ready is high whenever that
// register is empty or being drained, so a stalled receiver holds off the
// next word after one result is pending.
// cfg_we writes frames_in_use (0 acts as 1, above MAX_FRAMES acts as
// MAX_FRAMES); lowering it drops the least recent pages silently.
// Reset empties the stack, clears the fault count and sets frames_in_use to 4.
module lru_page_replacement_unit #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrup_pkg::FRAME_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lrup_pkg::PAGE_W-1:0]   page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fault,
  output logic                          evicted_valid,
  output logic [lrup_pkg::PAGE_W-1:0]   evicted_page,
  output logic [lrup_pkg::COUNT_W-1:0]  fault_total
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CW    = (CNT_W > lrup_pkg::FRAME_W) ? CNT_W : lrup_pkg::FRAME_W;

  logic [lrup_pkg::FRAME_W-1:0] frames_in_use;
  logic [CNT_W-1:0]             occupancy;
  logic [CNT_W-1:0]             occupancy_next;
  logic [lrup_pkg::COUNT_W-1:0] fault_counter;
  logic [lrup_pkg::COUNT_W-1:0] fault_counter_next;

  logic [CW-1:0]    cap_wide;
  logic [CW-1:0]    new_cap_wide;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] new_cap;
  logic [CNT_W-1:0] cap_m1;

  logic in_accept;
  logic miss;
  logic evict;

  lrup_pkg::chain_t            chain [MAX_FRAMES+1];
  logic [lrup_pkg::PAGE_W-1:0] entries [MAX_FRAMES];

  function automatic logic [CW-1:0] clamp_cap(input logic [lrup_pkg::FRAME_W-1:0] f);
    logic [CW-1:0] c;
    c = CW'(f);
    if (c == '0) c = CW'(1);
    if (c > CW'(MAX_FRAMES)) c = CW'(MAX_FRAMES);
    return c;
  endfunction

  assign cap_wide     = clamp_cap(frames_in_use);
  assign new_cap_wide = clamp_cap(cfg_wdata);
  assign cap          = cap_wide[CNT_W-1:0];
  assign new_cap      = new_cap_wide[CNT_W-1:0];
  assign cap_m1       = cap - CNT_W'(1);

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign chain[0] = '{seen: 1'b0, victim: '0};

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [lrup_pkg::PAGE_W-1:0] prev_entry;
    if (i == 0) begin : g_top
      assign prev_entry = page;
    end else begin : g_below
      assign prev_entry = entries[i-1];
    end
    lrup_cell u_cell (
      .clk        (clk),
      .shift_en   (in_accept),
      .page       (page),
      .prev_entry (prev_entry),
      .valid      (CNT_W'(i) < occupancy),
      .bottom     (CNT_W'(i) == cap_m1),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .entry      (entries[i])
    );
  end

  assign miss  = !chain[MAX_FRAMES].seen;
  assign evict = miss && (occupancy >= cap);

  always_comb begin
    occupancy_next     = occupancy;
    fault_counter_next = fault_counter;
    if (in_accept && miss) begin
      occupancy_next     = evict ? cap : occupancy + CNT_W'(1);
      fault_counter_next = fault_counter + lrup_pkg::COUNT_W'(1);
    end else if (cfg_we && (occupancy > new_cap)) begin
      occupancy_next = new_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrup_pkg::FRAMES_RESET;
      occupancy     <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      occupancy     <= occupancy_next;
      fault_counter <= fault_counter_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fault         <= miss;
      evicted_valid <= evict;
      evicted_page  <= evict ? chain[MAX_FRAMES].victim : '0;
      fault_total   <= fault_counter_next;
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_W'(MAX_FRAMES))
    else $error("occupancy beyond stack depth");

  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> fault)
    else $error("eviction reported on a hit");

  a_evict_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page not zero without eviction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_accept && miss |=> fault_counter == $past(fault_counter) + lrup_pkg::COUNT_W'(1))
    else $error("fault counter missed a step");
`endif

endmodule
